FILE: rtl/bnft_pkg.sv
`timescale 1ns / 1ps

package bnft_pkg;

    // Default width of the byte position counters
    localparam int OFFSET_BITS_DEF = 16;

    // Width of the offset and length fields on the result beat
    localparam int FIELD_BITS = 16;

    // Characters the lexer looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    // Lexer phase
    typedef enum logic [3:0] {
        PH_SKIP        = 4'd0,
        PH_HEAD_FIRST  = 4'd1,
        PH_HEAD_REST   = 4'd2,
        PH_PRE_ASSIGN  = 4'd3,
        PH_COLON2      = 4'd4,
        PH_EQ          = 4'd5,
        PH_BODY        = 4'd6,
        PH_BODY_FIRST  = 4'd7,
        PH_BODY_REST   = 4'd8,
        PH_LIT         = 4'd9
    } t_phase;

    // Token kinds; TK_NONE is internal and never leaves the block
    typedef enum logic [2:0] {
        TK_NAME   = 3'd0,
        TK_ASSIGN = 3'd1,
        TK_OR     = 3'd2,
        TK_LIT    = 3'd3,
        TK_END    = 3'd4,
        TK_ERROR  = 3'd5,
        TK_DONE   = 3'd6,
        TK_NONE   = 3'd7
    } t_kind;

    // Lexer control state
    typedef struct packed {
        t_phase phase;
        logic   dquote;     // literal opened with a double quote
        logic   cr_seen;    // CR waiting for its LF
        logic   hold;       // error seen, dropping bytes until NUL
        logic   past_end;   // position counter has run out
    } t_ctl;

    localparam t_ctl CTL_RESET = '{phase: PH_SKIP, dquote: 1'b0, cr_seen: 1'b0,
                                   hold: 1'b0, past_end: 1'b0};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_name_tail(input logic [7:0] c);
        return is_alpha(c) || (c inside {[8'h30:8'h39]}) || (c == CH_DASH);
    endfunction

endpackage

FILE: rtl/bnft_step.sv
`timescale 1ns / 1ps

// One lexer step: current state and one text byte in, next state and
// an optional token out. Pure logic, sits between the input and result
// registers of the top level.
module bnft_step import bnft_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  t_ctl                   i_ctl,
    input  logic [OFFSET_BITS-1:0] i_pos,
    input  logic [OFFSET_BITS-1:0] i_elem,
    input  logic [OFFSET_BITS-1:0] i_rule,
    input  logic [7:0]             i_byte,
    output t_ctl                   o_ctl,
    output logic [OFFSET_BITS-1:0] o_pos,
    output logic [OFFSET_BITS-1:0] o_elem,
    output logic [OFFSET_BITS-1:0] o_rule,
    output logic                   o_res_valid,
    output t_kind                  o_kind,
    output logic [FIELD_BITS-1:0]  o_start,
    output logic [FIELD_BITS-1:0]  o_len
);

    localparam int LW = OFFSET_BITS + 1;

    t_kind                  kind;
    logic                   fail;
    t_phase                 ph;
    logic                   dq;
    logic                   cr;
    logic [OFFSET_BITS-1:0] elem;
    logic [OFFSET_BITS-1:0] rule;
    logic [OFFSET_BITS-1:0] start;
    logic [LW-1:0]          len;
    logic [LW-1:0]          len_elem;
    logic [LW-1:0]          len_rule;
    logic                   pos_last;
    logic                   is_nul;

    logic [OFFSET_BITS-1:0] res_start;
    logic [LW-1:0]          res_len;
    logic [OFFSET_BITS+FIELD_BITS-1:0] start_ext;
    logic [LW+FIELD_BITS-1:0]          len_ext;

    // Span lengths from the element or rule start through this byte
    assign len_elem = {1'b0, i_pos} - {1'b0, i_elem} + LW'(1);
    assign len_rule = {1'b0, i_pos} - {1'b0, i_rule} + LW'(1);
    assign pos_last = (i_pos == '1);
    assign is_nul   = (i_byte == CH_NUL);

    // Decode the byte against the current phase
    always_comb begin
        kind  = TK_NONE;
        fail  = 1'b0;
        ph    = i_ctl.phase;
        dq    = i_ctl.dquote;
        cr    = i_ctl.cr_seen;
        elem  = i_elem;
        rule  = i_rule;
        start = i_pos;
        len   = '0;
        case (i_ctl.phase)
            PH_SKIP: begin
                if (i_ctl.cr_seen) begin
                    if (i_byte == CH_LF) cr = 1'b0;
                    else                 fail = 1'b1;
                end else if (i_byte inside {CH_SPACE, CH_TAB, CH_LF}) begin
                    cr = 1'b0;
                end else if (i_byte == CH_CR) begin
                    cr = 1'b1;
                end else if (is_nul) begin
                    kind = TK_DONE;
                end else if (i_byte == CH_LT) begin
                    rule = i_pos;
                    elem = i_pos;
                    ph   = PH_HEAD_FIRST;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_HEAD_FIRST, PH_BODY_FIRST: begin
                if (is_alpha(i_byte))
                    ph = (i_ctl.phase == PH_HEAD_FIRST) ? PH_HEAD_REST : PH_BODY_REST;
                else
                    fail = 1'b1;
            end
            PH_HEAD_REST, PH_BODY_REST: begin
                if (is_name_tail(i_byte)) begin
                    kind = TK_NONE;
                end else if (i_byte == CH_GT) begin
                    kind  = TK_NAME;
                    start = i_elem;
                    len   = len_elem;
                    ph    = (i_ctl.phase == PH_HEAD_REST) ? PH_PRE_ASSIGN : PH_BODY;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_PRE_ASSIGN: begin
                if (i_byte inside {CH_SPACE, CH_TAB}) begin
                    kind = TK_NONE;
                end else if (i_byte == CH_COLON) begin
                    elem = i_pos;
                    ph   = PH_COLON2;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_COLON2: begin
                if (i_byte == CH_COLON) ph = PH_EQ;
                else                    fail = 1'b1;
            end
            PH_EQ: begin
                if (i_byte == CH_EQ) begin
                    kind  = TK_ASSIGN;
                    start = i_elem;
                    len   = LW'(3);
                    ph    = PH_BODY;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_BODY: begin
                if (i_ctl.cr_seen) begin
                    if (i_byte == CH_LF) begin
                        cr    = 1'b0;
                        kind  = TK_END;
                        start = i_rule;
                        len   = len_rule;
                        ph    = PH_SKIP;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (i_byte inside {CH_SPACE, CH_TAB}) begin
                    kind = TK_NONE;
                end else if (i_byte == CH_BAR) begin
                    kind = TK_OR;
                    len  = LW'(1);
                end else if (i_byte == CH_LT) begin
                    elem = i_pos;
                    ph   = PH_BODY_FIRST;
                end else if (i_byte inside {CH_DQUOTE, CH_SQUOTE}) begin
                    dq   = (i_byte == CH_DQUOTE);
                    elem = i_pos;
                    ph   = PH_LIT;
                end else if (i_byte == CH_CR) begin
                    cr = 1'b1;
                end else if (i_byte == CH_LF) begin
                    kind  = TK_END;
                    start = i_rule;
                    len   = len_rule;
                    ph    = PH_SKIP;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_LIT: begin
                if ((i_ctl.dquote && i_byte == CH_DQUOTE) ||
                    (!i_ctl.dquote && i_byte == CH_SQUOTE)) begin
                    kind  = TK_LIT;
                    start = i_elem;
                    len   = len_elem;
                    ph    = PH_BODY;
                end else if (!(i_byte inside {[CH_PRINT_LO:CH_PRINT_HI]})) begin
                    fail = 1'b1;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb begin
        o_ctl  = i_ctl;
        o_pos  = i_pos;
        o_elem = i_elem;
        o_rule = i_rule;
        if (i_ctl.hold) begin
            if (is_nul) begin
                o_ctl = CTL_RESET;
                o_pos = '0; o_elem = '0; o_rule = '0;
            end
        end else if (i_ctl.past_end || fail) begin
            if (is_nul) begin
                o_ctl = CTL_RESET;
                o_pos = '0; o_elem = '0; o_rule = '0;
            end else begin
                o_ctl.hold = 1'b1;
            end
        end else if (kind == TK_DONE) begin
            o_ctl = CTL_RESET;
            o_pos = '0; o_elem = '0; o_rule = '0;
        end else begin
            o_ctl.phase   = ph;
            o_ctl.dquote  = dq;
            o_ctl.cr_seen = cr;
            o_elem        = elem;
            o_rule        = rule;
            if (pos_last) o_ctl.past_end = 1'b1;
            else          o_pos = i_pos + OFFSET_BITS'(1);
        end
    end

    // Token out
    always_comb begin
        o_res_valid = 1'b0;
        o_kind      = kind;
        res_start   = start;
        res_len     = len;
        if (i_ctl.hold) begin
            o_res_valid = 1'b0;
        end else if (i_ctl.past_end) begin
            o_res_valid = 1'b1;
            o_kind      = TK_ERROR;
            res_start   = '1;
            res_len     = '0;
        end else if (fail) begin
            o_res_valid = 1'b1;
            o_kind      = TK_ERROR;
            res_start   = i_pos;
            res_len     = '0;
        end else begin
            o_res_valid = (kind != TK_NONE);
        end
    end

    // Fit the offsets to the result field width
    assign start_ext = {{FIELD_BITS{1'b0}}, res_start};
    assign len_ext   = {{FIELD_BITS{1'b0}}, res_len};
    assign o_start   = start_ext[FIELD_BITS-1:0];
    assign o_len     = len_ext[FIELD_BITS-1:0];

endmodule

FILE: rtl/bnf_rule_tokenizer_core.sv
`timescale 1ns / 1ps

// Streaming BNF lexer. Grammar text enters one byte per beat on the slave
// side (NUL ends the text) and flat tokens leave on the master side: kind in
// tuser, start offset and length in tdata. A byte is taken every clock while
// the input side does not stall; each byte passes an input register, one
// pass of lexer logic that updates the phase and offset registers, and a
// result register. Bytes that complete no token give no output beat. The
// result register frees in the cycle it is taken, and the input side stalls
// only while a token waits on the master side, the master tready reaching
// the slave tready through one gate. After an error token the block drops
// bytes until NUL, which returns it to its reset state.
module bnf_rule_tokenizer_core import bnft_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] start_offset, [31:16] token_length
    output logic [2:0]  m_axis_tuser    // [2:0] token_kind
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    t_ctl                   r_ctl;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] r_elem;
    logic [OFFSET_BITS-1:0] r_rule;
    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [FIELD_BITS-1:0]  r_out_start;
    logic [FIELD_BITS-1:0]  r_out_len;

    t_ctl                   n_ctl;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] n_elem;
    logic [OFFSET_BITS-1:0] n_rule;
    logic                   n_out_valid;
    t_kind                  n_out_kind;
    logic [FIELD_BITS-1:0]  n_out_start;
    logic [FIELD_BITS-1:0]  n_out_len;

    logic adv;

    // Held byte moves on when the result register is free
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    bnft_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .i_ctl       (r_ctl),
        .i_pos       (r_pos),
        .i_elem      (r_elem),
        .i_rule      (r_rule),
        .i_byte      (r_in_byte),
        .o_ctl       (n_ctl),
        .o_pos       (n_pos),
        .o_elem      (n_elem),
        .o_rule      (n_rule),
        .o_res_valid (n_out_valid),
        .o_kind      (n_out_kind),
        .o_start     (n_out_start),
        .o_len       (n_out_len)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= CTL_RESET;
            r_pos  <= '0;
            r_elem <= '0;
            r_rule <= '0;
        end else if (adv) begin
            r_ctl  <= n_ctl;
            r_pos  <= n_pos;
            r_elem <= n_elem;
            r_rule <= n_rule;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_out_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && n_out_valid) begin
            r_out_kind  <= n_out_kind;
            r_out_start <= n_out_start;
            r_out_len   <= n_out_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_start};
    assign m_axis_tuser  = r_out_kind;

endmodule

FILE: rtl/bnft_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the tokenizer
module bnft_checker import bnft_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled token stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("token beat dropped while stalled");

    // With no token waiting the input side is always open
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no token waiting");

    // The internal no-token code never reaches the port
    a_no_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != TK_NONE)
        else $error("empty token kind on output");

    // Error and done tokens carry no length
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == TK_ERROR || m_axis_tuser == TK_DONE)
        |-> m_axis_tdata[31:16] == 16'd0)
        else $error("error or done token with non-zero length");

    // Fixed-size tokens: '|' is one byte, '::=' three
    a_fixed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == TK_OR || m_axis_tuser == TK_ASSIGN)
        |-> m_axis_tdata[31:16] == ((m_axis_tuser == TK_OR) ? 16'd1 : 16'd3))
        else $error("wrong length on or/assign token");

endmodule

bind bnf_rule_tokenizer_core bnft_checker u_bnft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/bnf_rule_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module bnf_rule_tokenizer_core_tb;
    import bnft_pkg::*;

    localparam int unsigned POS_LAST    = (1 << OFFSET_BITS_DEF) - 1;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          PHASE_ITEMS = 475;
    localparam int          HOLD_CYCLES = 400;

    // One token as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [15:0] offs;
        logic [15:0] len;
    } t_tok;

    // Per-beat tag: a token typed into the table overrides the prediction
    typedef struct packed {
        bit   on;
        t_tok t;
    } t_tag;

    typedef struct {
        string txt;
        int    reps;
        bit    nul;     // follow the text with a NUL beat
        bit    has_t;   // typed token for the last beat of the row
        t_tok  t;
    } t_stim_row;

    localparam t_tok NO_TOK = '{TK_NONE, 16'd0, 16'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [15:0] start_offset, [31:16] token_length
    logic [2:0]  m_axis_tuser;           // [2:0] token_kind

    t_tok        tok_expect_q[$];
    t_tag        byte_tag_q[$];
    logic [7:0]  txt_buf[$];
    t_stim_row   dir_tab[24];

    int          errors = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_cnt = 0;

    // Lexer state of the predictor
    t_phase      lx_phase;
    int unsigned lx_pos;
    int unsigned lx_elem;
    int unsigned lx_rule;
    bit          lx_dq;
    bit          lx_cr;
    bit          lx_hold;
    bit          lx_ovf;

    bnf_rule_tokenizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("bnf_rule_tokenizer_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void lex_clear();
        lx_phase = PH_SKIP;
        lx_pos   = 0;
        lx_elem  = 0;
        lx_rule  = 0;
        lx_dq    = 1'b0;
        lx_cr    = 1'b0;
        lx_hold  = 1'b0;
        lx_ovf   = 1'b0;
    endfunction

    // Folding bit 5 maps upper case onto lower case
    function automatic bit letter(input logic [7:0] c);
        return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
    endfunction

    function automatic bit name_char(input logic [7:0] c);
        return letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH;
    endfunction

    // Advance the lexer by one byte; returns 1 when a token comes out
    function automatic bit lex_byte(input logic [7:0] b, output t_tok tok);
        t_kind       k;
        int unsigned p;
        int unsigned st;
        int unsigned ln;
        bit          bad;
        k   = TK_NONE;
        p   = lx_pos;
        st  = 0;
        ln  = 0;
        bad = 1'b0;
        tok = NO_TOK;
        if (lx_hold) begin
            if (b == CH_NUL)
                lex_clear();
            return 1'b0;
        end
        if (lx_ovf) begin
            tok = '{TK_ERROR, 16'hFFFF, 16'd0};
            if (b == CH_NUL)
                lex_clear();
            else
                lx_hold = 1'b1;
            return 1'b1;
        end
        case (lx_phase)
            PH_SKIP: begin
                if (lx_cr) begin
                    if (b == CH_LF)
                        lx_cr = 1'b0;
                    else
                        bad = 1'b1;
                end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
                end else if (b == CH_CR) begin
                    lx_cr = 1'b1;
                end else if (b == CH_NUL) begin
                    k  = TK_DONE;
                    st = p;
                end else if (b == CH_LT) begin
                    lx_rule  = p;
                    lx_elem  = p;
                    lx_phase = PH_HEAD_FIRST;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_HEAD_FIRST, PH_BODY_FIRST: begin
                if (letter(b))
                    lx_phase = (lx_phase == PH_HEAD_FIRST) ? PH_HEAD_REST : PH_BODY_REST;
                else
                    bad = 1'b1;
            end
            PH_HEAD_REST, PH_BODY_REST: begin
                if (name_char(b)) begin
                end else if (b == CH_GT) begin
                    k  = TK_NAME;
                    st = lx_elem;
                    ln = p - lx_elem + 1;
                    lx_phase = (lx_phase == PH_HEAD_REST) ? PH_PRE_ASSIGN : PH_BODY;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_PRE_ASSIGN: begin
                if (b == CH_SPACE || b == CH_TAB) begin
                end else if (b == CH_COLON) begin
                    lx_elem  = p;
                    lx_phase = PH_COLON2;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_COLON2: begin
                if (b == CH_COLON)
                    lx_phase = PH_EQ;
                else
                    bad = 1'b1;
            end
            PH_EQ: begin
                if (b == CH_EQ) begin
                    k  = TK_ASSIGN;
                    st = lx_elem;
                    ln = 3;
                    lx_phase = PH_BODY;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_BODY: begin
                if (lx_cr) begin
                    if (b == CH_LF) begin
                        lx_cr = 1'b0;
                        k  = TK_END;
                        st = lx_rule;
                        ln = p - lx_rule + 1;
                        lx_phase = PH_SKIP;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (b == CH_SPACE || b == CH_TAB) begin
                end else if (b == CH_BAR) begin
                    k  = TK_OR;
                    st = p;
                    ln = 1;
                end else if (b == CH_LT) begin
                    lx_elem  = p;
                    lx_phase = PH_BODY_FIRST;
                end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    lx_dq    = (b == CH_DQUOTE);
                    lx_elem  = p;
                    lx_phase = PH_LIT;
                end else if (b == CH_CR) begin
                    lx_cr = 1'b1;
                end else if (b == CH_LF) begin
                    k  = TK_END;
                    st = lx_rule;
                    ln = p - lx_rule + 1;
                    lx_phase = PH_SKIP;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_LIT: begin
                if ((lx_dq && b == CH_DQUOTE) || (!lx_dq && b == CH_SQUOTE)) begin
                    k  = TK_LIT;
                    st = lx_elem;
                    ln = p - lx_elem + 1;
                    lx_phase = PH_BODY;
                end else if (b < CH_PRINT_LO || b > CH_PRINT_HI) begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase

        if (bad) begin
            tok = '{TK_ERROR, p[15:0], 16'd0};
            if (b == CH_NUL)
                lex_clear();
            else
                lx_hold = 1'b1;
            return 1'b1;
        end
        if (k == TK_DONE) begin
            tok = '{TK_DONE, st[15:0], 16'd0};
            lex_clear();
            return 1'b1;
        end
        if (p >= POS_LAST)
            lx_ovf = 1'b1;
        else
            lx_pos = p + 1;
        if (k != TK_NONE) begin
            tok = '{k, st[15:0], ln[15:0]};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- monitor

    // Predict on every input beat, check every output beat
    always @(posedge i_clk) begin : mon
        t_tag tg;
        t_tok tk;
        t_tok want;
        t_tok got;
        bit   hit;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tg  = byte_tag_q.pop_front();
                hit = lex_byte(s_axis_tdata, tk);
                if (tg.on)
                    tok_expect_q.push_back(tg.t);
                else if (hit)
                    tok_expect_q.push_back(tk);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{t_kind'(m_axis_tuser), m_axis_tdata[15:0], m_axis_tdata[31:16]};
                if (tok_expect_q.size() == 0) begin
                    $display("%0t: unexpected token, expected none, actual kind %0d start %0d len %0d",
                             $time, got.kind, got.offs, got.len);
                    errors++;
                end else begin
                    want = tok_expect_q.pop_front();
                    if (got.kind != want.kind) begin
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                        errors++;
                    end
                    if (got.offs != want.offs) begin
                        $display("%0t: start_offset expected %0d actual %0d",
                                 $time, want.offs, got.offs);
                        errors++;
                    end
                    if (got.len != want.len) begin
                        $display("%0t: token_length expected %0d actual %0d",
                                 $time, want.len, got.len);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic put_byte(input logic [7:0] b, input bit on, input t_tok t);
        byte_tag_q.push_back('{on, t});
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Rule name: '<', a letter, up to six tail characters, '>'
    function automatic void add_name();
        int c;
        txt_buf.push_back(CH_LT);
        c = $urandom_range(0, 51);
        txt_buf.push_back(8'(c < 26 ? 8'h41 + c : 8'h61 + c - 26));
        repeat ($urandom_range(0, 6)) begin
            c = $urandom_range(0, 62);
            if (c < 26)
                txt_buf.push_back(8'(8'h41 + c));
            else if (c < 52)
                txt_buf.push_back(8'(8'h61 + c - 26));
            else if (c < 62)
                txt_buf.push_back(8'(8'h30 + c - 52));
            else
                txt_buf.push_back(CH_DASH);
        end
        txt_buf.push_back(CH_GT);
    endfunction

    function automatic void add_blanks();
        repeat ($urandom_range(0, 2))
            txt_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_eol();
        if ($urandom_range(1))
            txt_buf.push_back(CH_CR);
        txt_buf.push_back(CH_LF);
    endfunction

    // Build one random text (NUL not included); returns the beats that count
    function automatic int build_text();
        int         sel;
        int         cut;
        int         n;
        logic [7:0] q;
        logic [7:0] c;
        txt_buf.delete();
        sel = $urandom_range(99);
        // pure noise
        if (sel < 5) begin
            n = $urandom_range(1, 20);
            repeat (n) txt_buf.push_back(8'($urandom_range(0, 255)));
            return n + 1;
        end
        repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 2))
                    0: txt_buf.push_back(CH_SPACE);
                    1: txt_buf.push_back(CH_TAB);
                    default: add_eol();
                endcase
            end
            add_name();
            add_blanks();
            txt_buf.push_back(CH_COLON);
            txt_buf.push_back(CH_COLON);
            txt_buf.push_back(CH_EQ);
            repeat ($urandom_range(0, 5)) begin
                add_blanks();
                case ($urandom_range(0, 2))
                    0: add_name();
                    1: txt_buf.push_back(CH_BAR);
                    default: begin
                        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                        txt_buf.push_back(q);
                        repeat ($urandom_range(0, 6)) begin
                            c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
                            // the matching quote would close early; swap it
                            if (c == q)
                                c = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
                            txt_buf.push_back(c);
                        end
                        txt_buf.push_back(q);
                    end
                endcase
            end
            add_blanks();
            add_eol();
        end
        // one corrupted byte
        if (sel < 20) begin
            cut = $urandom_range(0, txt_buf.size() - 1);
            txt_buf[cut] = 8'($urandom_range(0, 255));
            return cut + 1;
        end
        // text cut short, usually inside a rule
        if (sel < 25) begin
            cut = $urandom_range(1, txt_buf.size() - 1);
            while (txt_buf.size() > cut)
                void'(txt_buf.pop_back());
            return cut + 1;
        end
        return txt_buf.size() + 1;
    endfunction

    // ---------------------------------------------------------------- main

    initial begin
        int i;
        int r;
        int j;
        int sent;
        int ph;
        bit last;

        dir_tab = '{
            '{"",                         1,     1, 1, '{TK_DONE,  16'd0,     16'd0}},
            '{"<Az9->",                   1,     0, 1, '{TK_NAME,  16'd0,     16'd6}},
            '{" \t::=",                   1,     0, 0, NO_TOK},
            '{" \"' ~\"",                 1,     0, 0, NO_TOK},
            '{"\t|",                      1,     0, 0, NO_TOK},
            '{" 'a\"'",                   1,     0, 0, NO_TOK},
            '{" <b>",                     1,     0, 0, NO_TOK},
            '{"\015\n",                   1,     0, 0, NO_TOK},
            '{" \t\n\015\n<c> ::= <d>\n", 1,     1, 0, NO_TOK},
            '{"\015x",                    1,     0, 1, '{TK_ERROR, 16'd1,     16'd0}},
            '{"\377<a> ::= \n",           1,     1, 0, NO_TOK},
            '{"\377",                     1,     0, 1, '{TK_ERROR, 16'd0,     16'd0}},
            '{"ab",                       1,     1, 0, NO_TOK},
            '{"<e> ::= 'a\177",           1,     0, 1, '{TK_ERROR, 16'd10,    16'd0}},
            '{"\n",                       1,     1, 0, NO_TOK},
            '{"<f> ::= \015<",            1,     1, 0, NO_TOK},
            '{"<g> ::= 'x",               1,     1, 1, '{TK_ERROR, 16'd10,    16'd0}},
            '{"<1",                       1,     1, 0, NO_TOK},
            '{"<h> :=",                   1,     1, 0, NO_TOK},
            '{" ",                        65536, 1, 1, '{TK_ERROR, 16'hFFFF,  16'd0}},
            '{" ",                        65520, 0, 0, NO_TOK},
            '{"<i> ::= <j>\n",            1,     0, 0, NO_TOK},
            '{"    x",                    1,     0, 1, '{TK_ERROR, 16'hFFFF,  16'd0}},
            '{"y",                        1,     1, 0, NO_TOK}
        };

        lex_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: special cases, extreme bytes, position run-out
        for (i = 0; i < 24; i++) begin
            for (r = 0; r < dir_tab[i].reps; r++) begin
                for (j = 0; j < dir_tab[i].txt.len(); j++) begin
                    last = (r == dir_tab[i].reps - 1) && (j == dir_tab[i].txt.len() - 1)
                           && !dir_tab[i].nul;
                    put_byte(dir_tab[i].txt[j], dir_tab[i].has_t && last, dir_tab[i].t);
                end
            end
            if (dir_tab[i].nul)
                put_byte(CH_NUL, dir_tab[i].has_t, dir_tab[i].t);
        end

        // random texts under each idling mix
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sent += build_text();
                foreach (txt_buf[k])
                    put_byte(txt_buf[k], 1'b0, NO_TOK);
                put_byte(CH_NUL, 1'b0, NO_TOK);
            end
        end

        // long receiver hold-off while a burst of tokens is offered
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        txt_buf = '{CH_LT, 8'h70, CH_GT, CH_SPACE, CH_COLON, CH_COLON, CH_EQ};
        repeat (40) txt_buf.push_back(CH_BAR);
        txt_buf.push_back(CH_LF);
        txt_buf.push_back(CH_NUL);
        foreach (txt_buf[k])
            put_byte(txt_buf[k], 1'b0, NO_TOK);

        s_axis_tvalid <= 1'b0;
        while (tok_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("bnf_rule_tokenizer_core test passed");
        end else begin
            $display("bnf_rule_tokenizer_core test failed");
        end
        $finish;
    end

endmodule
